@@ hw/rtl/pds_pkg.sv @@
// Shared constants for the PLL post-divider select block.
// Widths of the request path, the divider limits and the region table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pds_pkg;

  // field and datapath widths
  localparam int REQ_W   = 32;  // requested clock, kHz
  localparam int VCO_W   = 16;  // VCO frequency, MHz
  localparam int PROD_W  = 28;  // VCO * 4000 always fits here
  localparam int NUM_W   = 33;  // product + request - 1
  localparam int QUART_W = 8;   // divider in quarter steps
  localparam int CODE_W  = 7;   // divider register code
  localparam int CLK_W   = 25;  // resulting clock, kHz

  // kHz per quarter step for a VCO of 1 MHz
  localparam logic [11:0] KHZ_PER_QUARTER = 12'd4000;

  // divider limits in quarters
  localparam logic [QUART_W-1:0] DEFAULT_QUARTERS = 8'hff;
  localparam logic [QUART_W-1:0] MIN_QUARTERS     = 8'd8;
  localparam logic [QUART_W-1:0] MAX_QUARTERS     = 8'd248;

  // region table: fine region steps by 1, middle by 2, coarse by 4
  localparam logic [QUART_W-1:0] FINE_HI    = 8'd64;
  localparam logic [QUART_W-1:0] MID_LO     = 8'd64;
  localparam logic [QUART_W-1:0] MID_HI     = 8'd128;
  localparam logic [CODE_W-1:0]  MID_BASE   = 7'd64;
  localparam logic [QUART_W-1:0] COARSE_LO  = 8'd128;
  localparam logic [CODE_W-1:0]  COARSE_BASE = 7'd96;
  localparam logic [CODE_W-1:0]  MAX_CODE   = 7'd126;

endpackage

`default_nettype wire

@@ hw/rtl/pds_div_cell.sv @@
// One restoring-division cell: shifts one dividend bit into the partial
// remainder, subtracts the divisor when it fits and shifts the quotient bit
// in. Registered stage with its own valid/ready. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pds_div_cell #(
  parameter int W = 8,   // remainder and divisor width
  parameter int N = 8,   // dividend / quotient shift register width
  parameter int S = 1    // sideband width
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [W-1:0] in_rem,
  input  wire logic [W-1:0] in_div,
  input  wire logic [N-1:0] in_acc,
  input  wire logic [S-1:0] in_side,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_rem,
  output logic [W-1:0]      out_div,
  output logic [N-1:0]      out_acc,
  output logic [S-1:0]      out_side
);

  logic         valid_r;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] div_r;
  logic [N-1:0] acc_r, acc_nxt;
  logic [S-1:0] side_r;
  logic [W:0]   rem_sh;
  logic [W:0]   diff;
  logic         fits;

  // stage takes a new request when empty or when its own is leaving
  assign in_ready = !valid_r || out_ready;

  // one division step
  always_comb begin
    rem_sh  = {in_rem, in_acc[N-1]};
    diff    = rem_sh - {1'b0, in_div};
    fits    = (rem_sh >= {1'b0, in_div});
    rem_nxt = fits ? diff[W-1:0] : rem_sh[W-1:0];
    acc_nxt = {in_acc[N-2:0], fits};
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= rem_nxt;
      div_r  <= in_div;
      acc_r  <= acc_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_div   = div_r;
  assign out_acc   = acc_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

@@ hw/rtl/pds_band_map.sv @@
// Clamp of the wanted divider and mapping into the three step regions.
// Registered stage with valid/ready. Depends on pds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pds_band_map (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pds_pkg::QUART_W-1:0]   in_quot,
  input  wire logic                          in_sat,
  input  wire logic [pds_pkg::PROD_W-1:0]    in_prod,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pds_pkg::CODE_W-1:0]         out_code,
  output logic [pds_pkg::QUART_W-1:0]        out_quarters,
  output logic [pds_pkg::PROD_W-1:0]         out_prod
);

  logic                          valid_r;
  logic [pds_pkg::CODE_W-1:0]    code_r, code_nxt;
  logic [pds_pkg::QUART_W-1:0]   quarters_r, quarters_nxt;
  logic [pds_pkg::PROD_W-1:0]    prod_r;
  logic [pds_pkg::QUART_W-1:0]   wanted;
  logic [pds_pkg::QUART_W-1:0]   q;
  logic [pds_pkg::QUART_W-1:0]   ofs;

  assign in_ready = !valid_r || out_ready;

  // clamp, then round up to the step of the region
  always_comb begin
    wanted = in_sat ? pds_pkg::DEFAULT_QUARTERS : in_quot;
    q = wanted;
    if (q > pds_pkg::MAX_QUARTERS) q = pds_pkg::MAX_QUARTERS;
    if (q < pds_pkg::MIN_QUARTERS) q = pds_pkg::MIN_QUARTERS;
    ofs = '0;
    priority if (q <= pds_pkg::FINE_HI) begin
      code_nxt     = q[pds_pkg::CODE_W-1:0];
      quarters_nxt = q;
    end else if (q <= pds_pkg::MID_HI) begin
      ofs          = q - pds_pkg::MID_LO + 8'd1;
      code_nxt     = pds_pkg::MID_BASE + {1'b0, ofs[6:1]};
      quarters_nxt = pds_pkg::MID_LO + {ofs[7:1], 1'b0};
    end else begin
      ofs          = q - pds_pkg::COARSE_LO + 8'd3;
      code_nxt     = pds_pkg::COARSE_BASE + {1'b0, ofs[7:2]};
      quarters_nxt = pds_pkg::COARSE_LO + {ofs[7:2], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      code_r     <= code_nxt;
      quarters_r <= quarters_nxt;
      prod_r     <= in_prod;
    end
  end

  assign out_valid    = valid_r;
  assign out_code     = code_r;
  assign out_quarters = quarters_r;
  assign out_prod     = prod_r;

endmodule

`default_nettype wire

@@ hw/rtl/pll_post_divider_select.sv @@
// Usage notes for pll_post_divider_select.
// Request channel (in_valid/in_ready): requested output clock in kHz.
// Result channel (out_valid/out_ready): divider code, achieved divider in
// quarter steps and the resulting clock in kHz, one result per request.
// Configuration: cfg_we/cfg_wdata write the VCO frequency in MHz; the
// VCO*4000 product is formed at the write, so a request may follow at once.
// Write it only while no request is in flight.
// Pipeline: 36 register stages: two entry stages, eight division cells for
// the divider, one region mapping stage and 25 division cells for the
// resulting clock.
// Throughput: one request per cycle while the output is not stalled; every
// stage is its own register with its own valid, so a stalled result at the
// output only holds the stages behind it once they have filled up, and bubbles are squeezed out.
// Reset: synchronous, active low; all stages empty, VCO register zero.
// Results come out in request order.
`timescale 1ns / 1ps
`default_nettype none

module pll_post_divider_select (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [pds_pkg::VCO_W-1:0]   cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [pds_pkg::REQ_W-1:0]   in_requested_clock_khz,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [pds_pkg::CODE_W-1:0]       out_divider_code,
  output logic [pds_pkg::QUART_W-1:0]      out_divider_quarters,
  output logic [pds_pkg::CLK_W-1:0]        out_actual_clock_khz
);

  localparam int QW    = pds_pkg::QUART_W;
  localparam int PW    = pds_pkg::PROD_W;
  localparam int RW    = pds_pkg::REQ_W;
  localparam int NW    = pds_pkg::NUM_W;
  localparam int CW    = pds_pkg::CLK_W;
  localparam int SIDE1 = PW + 1;
  localparam int SIDE2 = pds_pkg::CODE_W + QW;

  // VCO * 4000, formed when the register is written
  logic [PW-1:0] prod_r;
  logic [31:0]   prod_full;

  assign prod_full = {16'b0, cfg_wdata} * {20'b0, pds_pkg::KHZ_PER_QUARTER};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
    end else if (cfg_we) begin
      prod_r <= prod_full[PW-1:0];
    end
  end

  // entry stage: numerator for the rounded-up divide
  logic          a_valid_r, a_ready;
  logic [RW-1:0] a_req_r;
  logic [NW-1:0] a_num_r;
  logic [PW-1:0] a_prod_r;

  // saturation stage: quotient above eight bits or zero request
  logic          b_valid_r, b_ready;
  logic [RW-1:0] b_req_r;
  logic [NW-1:0] b_num_r;
  logic [PW-1:0] b_prod_r;
  logic          b_sat_r;

  assign in_ready = !a_valid_r || a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_req_r  <= in_requested_clock_khz;
      a_num_r  <= {5'b0, prod_r} + {1'b0, in_requested_clock_khz} - 33'd1;
      a_prod_r <= prod_r;
    end
  end

  assign a_ready = !b_valid_r || b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_valid_r) begin
      b_req_r  <= a_req_r;
      b_num_r  <= a_num_r;
      b_prod_r <= a_prod_r;
      b_sat_r  <= (a_req_r == '0) || ({7'b0, a_num_r[NW-1:QW]} >= a_req_r);
    end
  end

  // divider chain: eight cells, one quotient bit each
  logic             d_valid [QW+1];
  logic             d_ready [QW+1];
  logic [RW-1:0]    d_rem   [QW+1];
  logic [RW-1:0]    d_div   [QW+1];
  logic [QW-1:0]    d_acc   [QW+1];
  logic [SIDE1-1:0] d_side  [QW+1];

  assign d_valid[0] = b_valid_r;
  assign b_ready    = d_ready[0];
  assign d_rem[0]   = {7'b0, b_num_r[NW-1:QW]};
  assign d_div[0]   = b_req_r;
  assign d_acc[0]   = b_num_r[QW-1:0];
  assign d_side[0]  = {b_sat_r, b_prod_r};

  for (genvar i = 0; i < QW; i++) begin : g_qcell
    pds_div_cell #(
      .W(RW),
      .N(QW),
      .S(SIDE1)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (d_valid[i]),
      .in_ready  (d_ready[i]),
      .in_rem    (d_rem[i]),
      .in_div    (d_div[i]),
      .in_acc    (d_acc[i]),
      .in_side   (d_side[i]),
      .out_valid (d_valid[i+1]),
      .out_ready (d_ready[i+1]),
      .out_rem   (d_rem[i+1]),
      .out_div   (d_div[i+1]),
      .out_acc   (d_acc[i+1]),
      .out_side  (d_side[i+1])
    );
  end

  // clamp and region mapping
  logic                        m_valid, m_ready;
  logic [pds_pkg::CODE_W-1:0]  m_code;
  logic [QW-1:0]               m_quarters;
  logic [PW-1:0]               m_prod;

  pds_band_map u_map (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (d_valid[QW]),
    .in_ready     (d_ready[QW]),
    .in_quot      (d_acc[QW]),
    .in_sat       (d_side[QW][PW]),
    .in_prod      (d_side[QW][PW-1:0]),
    .out_valid    (m_valid),
    .out_ready    (m_ready),
    .out_code     (m_code),
    .out_quarters (m_quarters),
    .out_prod     (m_prod)
  );

  // clock chain: product / quarters; the top three quotient bits are
  // always zero since quarters is at least 8, so 25 cells suffice
  logic             c_valid [CW+1];
  logic             c_ready [CW+1];
  logic [QW-1:0]    c_rem   [CW+1];
  logic [QW-1:0]    c_div   [CW+1];
  logic [CW-1:0]    c_acc   [CW+1];
  logic [SIDE2-1:0] c_side  [CW+1];

  assign c_valid[0] = m_valid;
  assign m_ready    = c_ready[0];
  assign c_rem[0]   = {{(QW-(PW-CW)){1'b0}}, m_prod[PW-1:CW]};
  assign c_div[0]   = m_quarters;
  assign c_acc[0]   = m_prod[CW-1:0];
  assign c_side[0]  = {m_code, m_quarters};

  for (genvar i = 0; i < CW; i++) begin : g_ccell
    pds_div_cell #(
      .W(QW),
      .N(CW),
      .S(SIDE2)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_rem    (c_rem[i]),
      .in_div    (c_div[i]),
      .in_acc    (c_acc[i]),
      .in_side   (c_side[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_rem   (c_rem[i+1]),
      .out_div   (c_div[i+1]),
      .out_acc   (c_acc[i+1]),
      .out_side  (c_side[i+1])
    );
  end

  // result port straight from the last cell's registers
  assign out_valid            = c_valid[CW];
  assign c_ready[CW]          = out_ready;
  assign out_actual_clock_khz = c_acc[CW];
  assign out_divider_code     = c_side[CW][SIDE2-1:QW];
  assign out_divider_quarters = c_side[CW][QW-1:0];

  // checks
  a_quarters_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_divider_quarters >= pds_pkg::MIN_QUARTERS) &&
                  (out_divider_quarters <= pds_pkg::MAX_QUARTERS))
    else $error("achieved divider outside 8..248 quarters");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_divider_code >= pds_pkg::MIN_QUARTERS[6:0]) &&
                  (out_divider_code <= pds_pkg::MAX_CODE))
    else $error("divider code outside 8..126");

  a_fine_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_divider_quarters <= pds_pkg::FINE_HI) |->
      ({1'b0, out_divider_code} == out_divider_quarters))
    else $error("fine region code differs from divider");

  a_prod_load: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_we) && $past(rst_n) |-> (prod_r == $past(prod_full[PW-1:0])))
    else $error("VCO product not loaded on write");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !a_valid_r)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
